// ===== rtl/sflg_pkg.sv =====
package sflg_pkg;

  // Delay line geometry.
  localparam int DELAY_FRAMES = 2048;
  localparam int ADDR_W       = $clog2(DELAY_FRAMES);
  localparam int FRAC_W       = 8;
  localparam int DLY_W        = ADDR_W + FRAC_W;
  localparam int DMAX         = (DELAY_FRAMES - 1) * (1 << FRAC_W);

  // Sample format.
  localparam int SAMPLE_W = 16;

  // Sine table: quarter wave, entries 0 .. QUARTER inclusive.
  localparam int SINE_BITS = 10;
  localparam int QUARTER   = 1 << (SINE_BITS - 2);
  localparam int SIDX_W    = SINE_BITS - 1;
  localparam int SMAG_W    = 15;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Shared multiplier.
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HI_W    = PROD_W - 16;

  // Shared divider.
  localparam int DIV_N_W = 32;
  localparam int DIV_Q_W = 17;
  localparam int DIV_C_W = $clog2(DIV_Q_W + 1);

  // Gains.
  localparam int GAIN_W = 17;
  localparam logic [GAIN_W-1:0] UNITY_Q16 = 17'd65536;
  localparam logic [MUL_B_W-1:0] RECIP5   = 18'd52429;
  localparam logic [16:0] CLIP_THREE      = 17'd98304;
  localparam logic [16:0] CLIP_ONE        = 17'd32768;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE  = 3'd5;

  typedef struct packed {
    logic [31:0]       phase_step;
    logic [18:0]       center_delay;
    logic [18:0]       lfo_width;
    logic [GAIN_W-1:0] feedback_gain;
    logic [GAIN_W-1:0] wet_mix;
    logic [GAIN_W-1:0] output_scale;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SINE, ST_MUL_D, ST_DELAY, ST_RD_P, ST_RD_N, ST_CAP_N,
    ST_MUL_I, ST_INTERP, ST_MUL_FB, ST_CLIP_IN, ST_MUL_WM, ST_MIX, ST_MUL_OS,
    ST_OUT, ST_MUL_SQ, ST_X2, ST_MUL_5, ST_DIV1_GO, ST_DIV1, ST_DIV2_GO,
    ST_DIV2, ST_WRITE, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_SINE, OP_MUL_D, OP_DELAY, OP_RD_P, OP_RD_N,
    OP_CAP_N, OP_MUL_I, OP_INTERP, OP_MUL_FB, OP_CLIP_IN, OP_MUL_WM, OP_MIX,
    OP_MUL_OS, OP_OUT, OP_MUL_SQ, OP_X2, OP_MUL_5, OP_DIV1_GO, OP_DIV2_GO,
    OP_WRITE, OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ch;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

  typedef logic [QUARTER:0][SMAG_W-1:0] sine_rom_t;

  // Quarter-wave sine magnitude in Q15, built at elaboration by a Horner series.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] s15;
    int          a;
    rom = '0;
    for (a = 0; a <= QUARTER; a++) begin
      x   = (64'(a) * HALF_PI_Q30) / QUARTER;
      x2  = (x * x) >> 30;
      t   = ONE_Q30;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s   = (x * t) >> 30;
      s15 = (s + 64'd16384) >> 15;
      if (s15 > 64'd32767) begin
        s15 = 64'd32767;
      end
      rom[a] = s15[SMAG_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/sflg_ram.sv =====
module sflg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sflg_div.sv =====
module sflg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sflg_pkg::DIV_N_W-1:0]  num,
  input  logic [16:0]                   den,
  output logic                          busy,
  output logic [sflg_pkg::DIV_Q_W-1:0]  quo
);

  // Restoring division, one quotient bit a cycle. The caller guarantees that
  // the quotient fits in DIV_Q_W bits, so the leading bits are preloaded.
  logic [16:0]                         rem_r;
  logic [sflg_pkg::DIV_Q_W-1:0]        quo_r;
  logic [16:0]                         den_r;
  logic [sflg_pkg::DIV_C_W-1:0]        cnt_r;
  logic                                busy_r;
  logic [17:0]                         trial;
  logic                                fits;

  assign trial = {rem_r, quo_r[sflg_pkg::DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= sflg_pkg::DIV_C_W'(sflg_pkg::DIV_Q_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != sflg_pkg::DIV_C_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num[sflg_pkg::DIV_N_W-1:sflg_pkg::DIV_Q_W]};
      quo_r <= num[sflg_pkg::DIV_Q_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? 17'(trial - {1'b0, den_r}) : trial[16:0];
      quo_r <= {quo_r[sflg_pkg::DIV_Q_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/sflg_datapath.sv =====
module sflg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sflg_pkg::cfg_t       cfg,
  input  sflg_pkg::ctrl_t      ctrl,
  input  logic signed [15:0]   left_in,
  input  logic signed [15:0]   right_in,
  output sflg_pkg::stat_t      stat,
  output logic signed [15:0]   left_out,
  output logic signed [15:0]   right_out
);

  logic [31:0]                        phase_r;
  logic [sflg_pkg::ADDR_W-1:0]        wp_r;
  logic                               wrapped_r;
  logic signed [15:0]                 sine_r;
  logic signed [sflg_pkg::PROD_W-1:0] prod_r;
  logic [sflg_pkg::ADDR_W-1:0]        ip_r;
  logic [sflg_pkg::FRAC_W-1:0]        fr_r;
  logic                               rv_r;
  logic signed [15:0]                 x_r  [2];
  logic signed [15:0]                 pv_r [2];
  logic signed [15:0]                 nx_r [2];
  logic signed [15:0]                 o_r  [2];
  logic signed [15:0]                 dl_r;
  logic [15:0]                        ax_r;
  logic                               neg_r;
  logic signed [16:0]                 m_r;
  logic [16:0]                        x2_r;
  logic signed [15:0]                 left_out_r;
  logic signed [15:0]                 right_out_r;

  // Sine lookup with quarter-wave folding.
  logic [sflg_pkg::SINE_BITS-1:0]     k;
  logic [sflg_pkg::SINE_BITS-3:0]     r;
  logic [sflg_pkg::SIDX_W-1:0]        sidx;
  logic signed [15:0]                 mag;
  logic signed [15:0]                 sine_val;

  assign k    = phase_r[31 -: sflg_pkg::SINE_BITS];
  assign r    = k[sflg_pkg::SINE_BITS-3:0];
  assign sidx = k[sflg_pkg::SINE_BITS-2] ?
                sflg_pkg::SIDX_W'(sflg_pkg::QUARTER) - {1'b0, r} : {1'b0, r};
  assign mag  = $signed({1'b0, sflg_pkg::SINE_ROM[sidx]});
  assign sine_val = k[sflg_pkg::SINE_BITS-1] ? -mag : mag;

  // Shared multiplier operands.
  logic signed [sflg_pkg::MUL_A_W-1:0] mul_a;
  logic signed [sflg_pkg::MUL_B_W-1:0] mul_b;
  logic                                mul_en;
  logic signed [16:0]                  diff;
  logic [sflg_pkg::GAIN_W-1:0]         fb_sat;
  logic [sflg_pkg::GAIN_W-1:0]         wm_sat;
  logic signed [15:0]                  x_cur;

  assign x_cur  = x_r[ctrl.ch];
  assign diff   = 17'(nx_r[ctrl.ch]) - 17'(pv_r[ctrl.ch]);
  assign fb_sat = (cfg.feedback_gain > sflg_pkg::UNITY_Q16) ? sflg_pkg::UNITY_Q16
                                                             : cfg.feedback_gain;
  assign wm_sat = (cfg.wet_mix > sflg_pkg::UNITY_Q16) ? sflg_pkg::UNITY_Q16 : cfg.wet_mix;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (ctrl.op)
      sflg_pkg::OP_MUL_D: begin
        mul_a = $signed({1'b0, cfg.lfo_width});
        mul_b = 18'(sine_r);
      end
      sflg_pkg::OP_MUL_I: begin
        mul_a = 20'(diff);
        mul_b = $signed({10'b0, fr_r});
      end
      sflg_pkg::OP_MUL_FB: begin
        mul_a = $signed({3'b0, fb_sat});
        mul_b = 18'(dl_r);
      end
      sflg_pkg::OP_MUL_WM: begin
        mul_a = $signed({3'b0, wm_sat});
        mul_b = 18'(dl_r);
      end
      sflg_pkg::OP_MUL_OS: begin
        mul_a = 20'(m_r);
        mul_b = $signed({1'b0, cfg.output_scale});
      end
      sflg_pkg::OP_MUL_SQ: begin
        mul_a = $signed({4'b0, ax_r});
        mul_b = $signed({2'b0, ax_r});
      end
      sflg_pkg::OP_MUL_5: begin
        mul_a = $signed({3'b0, x2_r});
        mul_b = $signed(sflg_pkg::RECIP5);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Upper part of the product, i.e. floor(prod / 2^16).
  logic signed [sflg_pkg::HI_W-1:0] hi_s;
  assign hi_s = prod_r[sflg_pkg::PROD_W-1:16];

  // Delay in frames with fraction, clamped to the line.
  logic signed [22:0]             d_sum;
  logic [sflg_pkg::DLY_W-1:0]     d_cl;

  assign d_sum = 23'(hi_s) + $signed({4'b0, cfg.center_delay});

  always_comb begin
    if (d_sum < 0) begin
      d_cl = '0;
    end else if (d_sum > sflg_pkg::DMAX) begin
      d_cl = sflg_pkg::DLY_W'(sflg_pkg::DMAX);
    end else begin
      d_cl = d_sum[sflg_pkg::DLY_W-1:0];
    end
  end

  // Tap addresses; an entry not yet written since reset reads as zero.
  logic [sflg_pkg::ADDR_W-1:0] rd_addr;
  logic [15:0]                 rd_left;
  logic [15:0]                 rd_right;

  always_comb begin
    case (ctrl.op)
      sflg_pkg::OP_RD_N: rd_addr = wp_r - ip_r - sflg_pkg::ADDR_W'(fr_r != '0);
      default:           rd_addr = wp_r - ip_r;
    endcase
  end

  // Feedback sum, clamped, split into magnitude and sign.
  logic signed [22:0] v_sum;
  logic [15:0]        ax_val;
  logic               neg_val;

  assign v_sum = 23'(x_cur) + 23'(hi_s);

  always_comb begin
    if (v_sum > 65535) begin
      ax_val  = 16'hFFFF;
      neg_val = 1'b0;
    end else if (v_sum < -65535) begin
      ax_val  = 16'hFFFF;
      neg_val = 1'b1;
    end else begin
      neg_val = v_sum < 0;
      ax_val  = neg_val ? 16'(-v_sum) : 16'(v_sum);
    end
  end

  // Output saturation.
  logic signed [15:0] o_val;

  always_comb begin
    if (hi_s > 32767) begin
      o_val = 16'sh7FFF;
    end else if (hi_s < -32768) begin
      o_val = 16'sh8000;
    end else begin
      o_val = hi_s[15:0];
    end
  end

  // Divider.
  logic                           div_start;
  logic [sflg_pkg::DIV_N_W-1:0]   div_num;
  logic [16:0]                    div_den;
  logic                           div_busy;
  logic [sflg_pkg::DIV_Q_W-1:0]   div_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = {x2_r, 15'b0};
    div_den   = sflg_pkg::CLIP_THREE + {2'b0, prod_r[32:18]};
    case (ctrl.op)
      sflg_pkg::OP_DIV1_GO: begin
        div_start = 1'b1;
      end
      sflg_pkg::OP_DIV2_GO: begin
        div_start = 1'b1;
        div_num   = {1'b0, ax_r, 15'b0};
        div_den   = sflg_pkg::CLIP_ONE + div_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  sflg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  // Soft-clipped write value.
  logic [15:0] wr_val;

  always_comb begin
    if (neg_r) begin
      wr_val = (div_q > 17'd32768) ? 16'h8000 : 16'(-$signed({1'b0, div_q}));
    end else begin
      wr_val = (div_q > 17'd32767) ? 16'h7FFF : div_q[15:0];
    end
  end

  logic we_left;
  logic we_right;

  assign we_left  = (ctrl.op == sflg_pkg::OP_WRITE) && !ctrl.ch;
  assign we_right = (ctrl.op == sflg_pkg::OP_WRITE) && ctrl.ch;

  sflg_ram #(.WIDTH(16), .DEPTH(sflg_pkg::DELAY_FRAMES)) u_ram_left (
    .clk   (clk),
    .we    (we_left),
    .waddr (wp_r),
    .wdata (wr_val),
    .raddr (rd_addr),
    .rdata (rd_left)
  );

  sflg_ram #(.WIDTH(16), .DEPTH(sflg_pkg::DELAY_FRAMES)) u_ram_right (
    .clk   (clk),
    .we    (we_right),
    .waddr (wp_r),
    .wdata (wr_val),
    .raddr (rd_addr),
    .rdata (rd_right)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      case (ctrl.op)
        sflg_pkg::OP_ACCEPT: begin
          phase_r <= phase_r + cfg.phase_step;
        end
        sflg_pkg::OP_LOAD_OUT: begin
          wp_r <= wp_r + 1'b1;
          if (wp_r == sflg_pkg::ADDR_W'(sflg_pkg::DELAY_FRAMES - 1)) begin
            wrapped_r <= 1'b1;
          end
        end
        default: begin
          wp_r <= wp_r;
        end
      endcase
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    rv_r <= wrapped_r || (rd_addr < wp_r);
    if (mul_en) begin
      prod_r <= sflg_pkg::PROD_W'(mul_a) * sflg_pkg::PROD_W'(mul_b);
    end
    case (ctrl.op)
      sflg_pkg::OP_ACCEPT: begin
        x_r[0] <= left_in;
        x_r[1] <= right_in;
      end
      sflg_pkg::OP_SINE: begin
        sine_r <= sine_val;
      end
      sflg_pkg::OP_DELAY: begin
        ip_r <= d_cl[sflg_pkg::DLY_W-1:sflg_pkg::FRAC_W];
        fr_r <= d_cl[sflg_pkg::FRAC_W-1:0];
      end
      sflg_pkg::OP_RD_N: begin
        pv_r[0] <= rv_r ? rd_left : '0;
        pv_r[1] <= rv_r ? rd_right : '0;
      end
      sflg_pkg::OP_CAP_N: begin
        nx_r[0] <= rv_r ? rd_left : '0;
        nx_r[1] <= rv_r ? rd_right : '0;
      end
      sflg_pkg::OP_INTERP: begin
        dl_r <= pv_r[ctrl.ch] + 16'(prod_r[sflg_pkg::PROD_W-1:8]);
      end
      sflg_pkg::OP_CLIP_IN: begin
        ax_r  <= ax_val;
        neg_r <= neg_val;
      end
      sflg_pkg::OP_MIX: begin
        m_r <= 17'(x_cur) + 17'(hi_s);
      end
      sflg_pkg::OP_OUT: begin
        o_r[ctrl.ch] <= o_val;
      end
      sflg_pkg::OP_X2: begin
        x2_r <= prod_r[31:15];
      end
      sflg_pkg::OP_LOAD_OUT: begin
        left_out_r  <= o_r[0];
        right_out_r <= o_r[1];
      end
      default: begin
        dl_r <= dl_r;
      end
    endcase
  end

  assign stat.div_busy = div_busy;
  assign left_out      = left_out_r;
  assign right_out     = right_out_r;

endmodule

// ===== rtl/sflg_ctrl.sv =====
module sflg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  sflg_pkg::stat_t stat,
  output sflg_pkg::ctrl_t ctrl
);

  sflg_pkg::state_t state_r;
  sflg_pkg::state_t state_nxt;
  logic             ch_r;
  logic             ch_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             can_load;

  // The finished item may be loaded once the output register is free or drains.
  assign can_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sflg_pkg::ST_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      sflg_pkg::ST_IDLE:    if (in_valid) state_nxt = sflg_pkg::ST_SINE;
      sflg_pkg::ST_SINE:    state_nxt = sflg_pkg::ST_MUL_D;
      sflg_pkg::ST_MUL_D:   state_nxt = sflg_pkg::ST_DELAY;
      sflg_pkg::ST_DELAY:   state_nxt = sflg_pkg::ST_RD_P;
      sflg_pkg::ST_RD_P:    state_nxt = sflg_pkg::ST_RD_N;
      sflg_pkg::ST_RD_N:    state_nxt = sflg_pkg::ST_CAP_N;
      sflg_pkg::ST_CAP_N:   state_nxt = sflg_pkg::ST_MUL_I;
      sflg_pkg::ST_MUL_I:   state_nxt = sflg_pkg::ST_INTERP;
      sflg_pkg::ST_INTERP:  state_nxt = sflg_pkg::ST_MUL_FB;
      sflg_pkg::ST_MUL_FB:  state_nxt = sflg_pkg::ST_CLIP_IN;
      sflg_pkg::ST_CLIP_IN: state_nxt = sflg_pkg::ST_MUL_WM;
      sflg_pkg::ST_MUL_WM:  state_nxt = sflg_pkg::ST_MIX;
      sflg_pkg::ST_MIX:     state_nxt = sflg_pkg::ST_MUL_OS;
      sflg_pkg::ST_MUL_OS:  state_nxt = sflg_pkg::ST_OUT;
      sflg_pkg::ST_OUT:     state_nxt = sflg_pkg::ST_MUL_SQ;
      sflg_pkg::ST_MUL_SQ:  state_nxt = sflg_pkg::ST_X2;
      sflg_pkg::ST_X2:      state_nxt = sflg_pkg::ST_MUL_5;
      sflg_pkg::ST_MUL_5:   state_nxt = sflg_pkg::ST_DIV1_GO;
      sflg_pkg::ST_DIV1_GO: state_nxt = sflg_pkg::ST_DIV1;
      sflg_pkg::ST_DIV1:    if (!stat.div_busy) state_nxt = sflg_pkg::ST_DIV2_GO;
      sflg_pkg::ST_DIV2_GO: state_nxt = sflg_pkg::ST_DIV2;
      sflg_pkg::ST_DIV2:    if (!stat.div_busy) state_nxt = sflg_pkg::ST_WRITE;
      sflg_pkg::ST_WRITE: begin
        ch_nxt    = !ch_r;
        state_nxt = ch_r ? sflg_pkg::ST_FIN : sflg_pkg::ST_MUL_I;
      end
      sflg_pkg::ST_FIN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = sflg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sflg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.ch = ch_r;
    case (state_r)
      sflg_pkg::ST_IDLE:    ctrl.op = in_valid ? sflg_pkg::OP_ACCEPT : sflg_pkg::OP_NONE;
      sflg_pkg::ST_SINE:    ctrl.op = sflg_pkg::OP_SINE;
      sflg_pkg::ST_MUL_D:   ctrl.op = sflg_pkg::OP_MUL_D;
      sflg_pkg::ST_DELAY:   ctrl.op = sflg_pkg::OP_DELAY;
      sflg_pkg::ST_RD_P:    ctrl.op = sflg_pkg::OP_RD_P;
      sflg_pkg::ST_RD_N:    ctrl.op = sflg_pkg::OP_RD_N;
      sflg_pkg::ST_CAP_N:   ctrl.op = sflg_pkg::OP_CAP_N;
      sflg_pkg::ST_MUL_I:   ctrl.op = sflg_pkg::OP_MUL_I;
      sflg_pkg::ST_INTERP:  ctrl.op = sflg_pkg::OP_INTERP;
      sflg_pkg::ST_MUL_FB:  ctrl.op = sflg_pkg::OP_MUL_FB;
      sflg_pkg::ST_CLIP_IN: ctrl.op = sflg_pkg::OP_CLIP_IN;
      sflg_pkg::ST_MUL_WM:  ctrl.op = sflg_pkg::OP_MUL_WM;
      sflg_pkg::ST_MIX:     ctrl.op = sflg_pkg::OP_MIX;
      sflg_pkg::ST_MUL_OS:  ctrl.op = sflg_pkg::OP_MUL_OS;
      sflg_pkg::ST_OUT:     ctrl.op = sflg_pkg::OP_OUT;
      sflg_pkg::ST_MUL_SQ:  ctrl.op = sflg_pkg::OP_MUL_SQ;
      sflg_pkg::ST_X2:      ctrl.op = sflg_pkg::OP_X2;
      sflg_pkg::ST_MUL_5:   ctrl.op = sflg_pkg::OP_MUL_5;
      sflg_pkg::ST_DIV1_GO: ctrl.op = sflg_pkg::OP_DIV1_GO;
      sflg_pkg::ST_DIV2_GO: ctrl.op = sflg_pkg::OP_DIV2_GO;
      sflg_pkg::ST_WRITE:   ctrl.op = sflg_pkg::OP_WRITE;
      sflg_pkg::ST_FIN:     ctrl.op = can_load ? sflg_pkg::OP_LOAD_OUT : sflg_pkg::OP_NONE;
      default:              ctrl.op = sflg_pkg::OP_NONE;
    endcase
  end

  assign in_stall  = state_r != sflg_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/stereo_flanger.sv =====
// Stereo flanger with feedback: each item is one Q1.15 stereo frame in and one
// saturated stereo frame out. A 32-bit LFO phase steps by phase_step per item and
// addresses a quarter-wave sine table; the delay (frames with 8 fraction bits) is
// center_delay plus half of lfo_width times the sine, clamped to the 2048-frame
// delay lines, and the two neighbouring taps are interpolated linearly. Each line
// stores a rational tanh soft clip of input plus feedback. An item runs from
// acceptance through the per-frame steps, the per-channel steps for the two
// channels in turn, and the load of the result, which waits until the output
// register is free or drains; only then can the next item be accepted. A
// single shared multiplier and a single one-bit-per-cycle divider serve both
// channels, and the four 17-step divisions of the soft clip, with their wait
// for completion, account for most of the time that an item takes. The input
// is taken only while the sequencer is idle; a finished frame waits in an
// output register, so the next item may be accepted before it is taken. The
// delay lines read as zero after reset with no clearing pass: an entry counts
// as written once the write pointer has passed it.
module stereo_flanger (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 in_left_in,
  input  logic signed [15:0]                 in_right_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 out_left_out,
  output logic signed [15:0]                 out_right_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sflg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sflg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers. Writes must arrive only while the block is idle, which
  // the block itself does not enforce; every write is taken.
  logic [31:0]                 phase_step_r;
  logic [18:0]                 center_delay_r;
  logic [18:0]                 lfo_width_r;
  logic [sflg_pkg::GAIN_W-1:0] feedback_gain_r;
  logic [sflg_pkg::GAIN_W-1:0] wet_mix_r;
  logic [sflg_pkg::GAIN_W-1:0] output_scale_r;
  logic                        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      center_delay_r  <= '0;
      lfo_width_r     <= '0;
      feedback_gain_r <= 17'd16384;
      wet_mix_r       <= 17'd65536;
      output_scale_r  <= 17'd46396;
    end else if (cfg_we) begin
      case (cfg_index)
        sflg_pkg::REG_PHASE_STEP:    phase_step_r    <= cfg_data;
        sflg_pkg::REG_CENTER_DELAY:  center_delay_r  <= cfg_data[18:0];
        sflg_pkg::REG_LFO_WIDTH:     lfo_width_r     <= cfg_data[18:0];
        sflg_pkg::REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[sflg_pkg::GAIN_W-1:0];
        sflg_pkg::REG_WET_MIX:       wet_mix_r       <= cfg_data[sflg_pkg::GAIN_W-1:0];
        sflg_pkg::REG_OUTPUT_SCALE:  output_scale_r  <= cfg_data[sflg_pkg::GAIN_W-1:0];
        default:                     phase_step_r    <= phase_step_r;
      endcase
    end
  end

  sflg_pkg::cfg_t cfg;

  assign cfg.phase_step    = phase_step_r;
  assign cfg.center_delay  = center_delay_r;
  assign cfg.lfo_width     = lfo_width_r;
  assign cfg.feedback_gain = feedback_gain_r;
  assign cfg.wet_mix       = wet_mix_r;
  assign cfg.output_scale  = output_scale_r;

  sflg_pkg::ctrl_t ctrl;
  sflg_pkg::stat_t stat;

  // The sequencer walks the per-frame steps and then both channels in turn.
  sflg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The datapath holds the LFO, the delay lines, the shared arithmetic and the
  // output register.
  sflg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .left_in   (in_left_in),
    .right_in  (in_right_in),
    .stat      (stat),
    .left_out  (out_left_out),
    .right_out (out_right_out)
  );

`ifndef SYNTHESIS
  // An accepted item always starts with the sine lookup.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (ctrl.op == sflg_pkg::OP_SINE))
    else $error("accepted item did not start the sequence");

  // A division that is started must be running in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == sflg_pkg::OP_DIV1_GO || ctrl.op == sflg_pkg::OP_DIV2_GO)
      |=> stat.div_busy)
    else $error("divider did not start");

  // The soft-clip result is written only after the divider has finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == sflg_pkg::OP_WRITE) |-> !stat.div_busy)
    else $error("delay line written while the divider was busy");

  // A new result is loaded only when the output register is free or drains.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == sflg_pkg::OP_LOAD_OUT) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");
`endif

endmodule

// ===== bench/tb_stereo_flanger.sv =====
module tb_stereo_flanger;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is ended by force if it goes on past this many clock cycles.
  localparam int CYCLE_LIMIT = 1000000;
  // Cycles allowed after the last result, well above the frame time.
  localparam int TAIL_CYCLES = 300;
  // Length of the long receiver hold-off in the pressure test.
  localparam int HOLD_CYCLES = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_left_in = '0;
  logic signed [15:0] in_right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_left_out;
  logic signed [15:0] out_right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sflg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sflg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stereo_flanger uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_in(in_left_in), .in_right_in(in_right_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // One stereo frame, as sent and as expected back.
  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  // Predicted output frames, oldest first, waiting for the block to deliver them.
  frame_t expected_frames[$];

  // Mirror of the block's state and registers, kept by the flanger predictor.
  logic signed [15:0] echo_left[sflg_pkg::DELAY_FRAMES];
  logic signed [15:0] echo_right[sflg_pkg::DELAY_FRAMES];
  logic [sflg_pkg::ADDR_W-1:0] echo_wr_ptr;
  logic [31:0] lfo_acc;
  sflg_pkg::cfg_t flanger_regs;

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  int stall_mode = 0;

  // Signed sine of the LFO phase in Q15, from the top ten phase bits with
  // quarter-wave folding and a Horner series evaluated in Q30.
  function automatic longint lfo_sine(logic [31:0] phase);
    longint unsigned k, quad, r, a, x, x2, t, s, s15;
    int unsigned divs[5];
    int i;
    divs = '{110, 72, 42, 20, 6};
    k = phase >> 22;
    quad = (k >> 8) & 3;
    r = k & 255;
    a = quad[0] ? 256 - r : r;
    x = (a * sflg_pkg::HALF_PI_Q30) / 256;
    x2 = (x * x) >> 30;
    t = sflg_pkg::ONE_Q30;
    for (i = 0; i < 5; i++) begin
      t = sflg_pkg::ONE_Q30 - ((x2 * t) >> 30) / divs[i];
    end
    s = (x * t) >> 30;
    s15 = (s + 16384) >> 15;
    if (s15 > 32767) begin
      s15 = 32767;
    end
    return quad[1] ? -longint'(s15) : longint'(s15);
  endfunction

  function automatic logic signed [15:0] clamp_sample(longint v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  // Rational tanh approximation on the magnitude, sign restored afterwards.
  function automatic logic signed [15:0] tanh_clip(longint v);
    longint ax, x2, inner, t, y;
    if (v > 65535) begin
      v = 65535;
    end
    if (v < -65535) begin
      v = -65535;
    end
    ax = (v < 0) ? -v : v;
    x2 = (ax * ax) >> 15;
    inner = 98304 + x2 / 5;
    t = (x2 << 15) / inner;
    y = (ax << 15) / (32768 + t);
    return clamp_sample((v < 0) ? -y : y);
  endfunction

  // Advances the predicted block by one frame and returns the frame it emits.
  function automatic frame_t flanger_step(frame_t src);
    longint s, d, fb, wm, ip, fr, inext, wp, iprev, inxt;
    longint x, pv, nx, tap, v, m;
    frame_t res;
    int c;
    lfo_acc = lfo_acc + flanger_regs.phase_step;
    s = lfo_sine(lfo_acc);
    d = longint'(flanger_regs.center_delay)
        + ((longint'(flanger_regs.lfo_width) * s) >>> 16);
    if (d < 0) begin
      d = 0;
    end
    if (d > sflg_pkg::DMAX) begin
      d = sflg_pkg::DMAX;
    end
    fb = (flanger_regs.feedback_gain > sflg_pkg::UNITY_Q16) ? 65536
                                                           : longint'(flanger_regs.feedback_gain);
    wm = (flanger_regs.wet_mix > sflg_pkg::UNITY_Q16) ? 65536
                                                     : longint'(flanger_regs.wet_mix);
    ip = d >> 8;
    fr = d & 255;
    inext = ip + ((fr != 0) ? 1 : 0);
    wp = echo_wr_ptr;
    iprev = (wp + sflg_pkg::DELAY_FRAMES - ip) % sflg_pkg::DELAY_FRAMES;
    inxt = (wp + sflg_pkg::DELAY_FRAMES - inext) % sflg_pkg::DELAY_FRAMES;
    for (c = 0; c < 2; c++) begin
      x = c ? src.right : src.left;
      pv = c ? echo_right[iprev] : echo_left[iprev];
      nx = c ? echo_right[inxt] : echo_left[inxt];
      tap = (pv * (256 - fr) + nx * fr) >>> 8;
      v = x + ((fb * tap) >>> 16);
      m = (x * 65536 + wm * tap) >>> 16;
      if (c) begin
        res.right = clamp_sample((m * longint'(flanger_regs.output_scale)) >>> 16);
        echo_right[wp] = tanh_clip(v);
      end else begin
        res.left = clamp_sample((m * longint'(flanger_regs.output_scale)) >>> 16);
        echo_left[wp] = tanh_clip(v);
      end
    end
    echo_wr_ptr = echo_wr_ptr + 1'b1;
    return res;
  endfunction

  initial begin
    for (int i = 0; i < sflg_pkg::DELAY_FRAMES; i++) begin
      echo_left[i] = '0;
      echo_right[i] = '0;
    end
    echo_wr_ptr = '0;
    lfo_acc = '0;
    flanger_regs = '{phase_step: 32'd0, center_delay: 19'd0, lfo_width: 19'd0,
                     feedback_gain: 17'd16384, wet_mix: 17'd65536,
                     output_scale: 17'd46396};
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure. The stall pattern is chosen at random among none,
  // random and periodic; a requested hold-off overrides it.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (cycle_count % 400 == 0) begin
      stall_mode = $urandom_range(0, 2);
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_mode == 1) begin
      out_stall <= $urandom_range(0, 1);
    end else if (stall_mode == 2) begin
      out_stall <= (cycle_count % 7) < 3;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every accepted output frame is compared with the oldest prediction.
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output frame: left %0d right %0d", out_left_out,
                   out_right_out);
        end
      end else begin
        want = expected_frames.pop_front();
        if (out_left_out !== want.left || out_right_out !== want.right) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("frame mismatch: expected left %0d right %0d, got left %0d right %0d",
                     want.left, want.right, out_left_out, out_right_out);
          end
        end
      end
    end
  end

  // Offers one frame, keeping valid high across a burst and idling between
  // bursts. Valid is not lowered here after acceptance, so back-to-back items
  // within a burst see no gap.
  task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r);
    frame_t src;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    do @(posedge clk); while (in_stall);
    src.left = l;
    src.right = r;
    expected_frames.push_back(flanger_step(src));
    burst_left--;
  endtask

  // Stops offering and waits until every predicted frame has come back.
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [sflg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sflg_pkg::REG_PHASE_STEP:    flanger_regs.phase_step = val;
      sflg_pkg::REG_CENTER_DELAY:  flanger_regs.center_delay = val[18:0];
      sflg_pkg::REG_LFO_WIDTH:     flanger_regs.lfo_width = val[18:0];
      sflg_pkg::REG_FEEDBACK_GAIN: flanger_regs.feedback_gain = val[16:0];
      sflg_pkg::REG_WET_MIX:       flanger_regs.wet_mix = val[16:0];
      sflg_pkg::REG_OUTPUT_SCALE:  flanger_regs.output_scale = val[16:0];
      default: ;
    endcase
  endtask

  // Writes all six registers while the block is idle, plus a write to an
  // unused index that must leave everything unchanged.
  task automatic apply_config(sflg_pkg::cfg_t c);
    write_reg(sflg_pkg::REG_PHASE_STEP, c.phase_step);
    write_reg(sflg_pkg::REG_CENTER_DELAY, 32'(c.center_delay));
    write_reg(sflg_pkg::REG_LFO_WIDTH, 32'(c.lfo_width));
    write_reg(sflg_pkg::REG_FEEDBACK_GAIN, 32'(c.feedback_gain));
    write_reg(sflg_pkg::REG_WET_MIX, 32'(c.wet_mix));
    write_reg(sflg_pkg::REG_OUTPUT_SCALE, 32'(c.output_scale));
    write_reg(sflg_pkg::CFG_IDX_W'($urandom_range(6, 7)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Default registers give zero delay, so each tap returns the oldest sample.
  task automatic test_sample_extremes;
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd32767, 16'sd32767);
    send_frame(-16'sd1, 16'sd1);
    send_frame(-16'sd32768, -16'sd32768);
    drain();
  endtask

  // Delay clamped at the top of the line, clamped below zero, and a
  // fractional delay that interpolates between two taps.
  task automatic test_delay_limits;
    apply_config('{phase_step: 32'd0, center_delay: 19'h7FFFF, lfo_width: 19'd0,
                   feedback_gain: 17'd16384, wet_mix: 17'd65536,
                   output_scale: 17'd46396});
    send_frame(16'sd20000, -16'sd20000);
    send_frame(16'sd32767, -16'sd32768);
    drain();
    apply_config('{phase_step: 32'h4000_0000, center_delay: 19'd0, lfo_width: 19'h7FFFF,
                   feedback_gain: 17'd65536, wet_mix: 17'd32768,
                   output_scale: 17'd50000});
    repeat (4) send_frame(pick_sample(), pick_sample());
    drain();
    apply_config('{phase_step: 32'hFFFF_FFFF, center_delay: 19'h180, lfo_width: 19'd512,
                   feedback_gain: 17'd40000, wet_mix: 17'd65536,
                   output_scale: 17'd46396});
    repeat (4) send_frame(pick_sample(), pick_sample());
    drain();
  endtask

  // Gains above unity saturate; output scale is applied as written, from zero
  // up to its largest value. Full-scale feedback pushes the soft clip hard.
  task automatic test_gain_saturation;
    apply_config('{phase_step: 32'd0, center_delay: 19'd0, lfo_width: 19'd0,
                   feedback_gain: 17'h1FFFF, wet_mix: 17'h1FFFF,
                   output_scale: 17'h1FFFF});
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(-16'sd32768, 16'sd32767);
    drain();
    apply_config('{phase_step: 32'd0, center_delay: 19'd256, lfo_width: 19'd0,
                   feedback_gain: 17'd65536, wet_mix: 17'd0, output_scale: 17'd0});
    send_frame(16'sd32767, 16'sd32767);
    send_frame(16'sd32767, 16'sd32767);
    drain();
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so
  // the output register and the sequencer both fill and the input stalls.
  task automatic test_backpressure;
    apply_config('{phase_step: $urandom, center_delay: 19'd2000, lfo_width: 19'd4000,
                   feedback_gain: 17'd30000, wet_mix: 17'd50000,
                   output_scale: 17'd52000});
    hold_request = 1'b1;
    burst_left = 20;
    repeat (10) send_frame(pick_sample(), pick_sample());
    drain();
  endtask

  // Random phases, each with its own register setting; the first and last
  // use extreme settings, the rest random ones mostly in the useful range.
  task automatic test_random_frames;
    sflg_pkg::cfg_t c;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        c = '{phase_step: 32'hFFFF_FFFF, center_delay: 19'h7FFFF, lfo_width: 19'h7FFFF,
              feedback_gain: 17'd65536, wet_mix: 17'd65536, output_scale: 17'd65536};
      end else if (p == 7) begin
        c = '{phase_step: 32'd1, center_delay: 19'd0, lfo_width: 19'd0,
              feedback_gain: 17'd0, wet_mix: 17'd0, output_scale: 17'd46396};
      end else begin
        c.phase_step = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
        c.center_delay = $urandom_range(0, 524287);
        c.lfo_width = $urandom_range(0, 524287);
        c.feedback_gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 65536);
        c.wet_mix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(0, 65536);
        c.output_scale = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                    : $urandom_range(46396, 65536);
      end
      apply_config(c);
      repeat (115) send_frame(pick_sample(), pick_sample());
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_extremes();
    test_delay_limits();
    test_gain_saturation();
    test_backpressure();
    test_random_frames();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
